// ===== hw/rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, constants and the command struct for the LRU cache cell row.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // capacity after reset
    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    // value returned by a get that misses
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // broadcast from the control to every cell in the execute cycle
    typedef struct packed {
        logic update;   // a set is being applied this cycle
        logic hit_any;  // key found somewhere in the row
        logic evict;    // miss with the row at capacity: drop the oldest
    } t_cell_cmd;

endpackage

// ===== hw/rtl/lkvc_cell.sv =====
// ----------------------------------------------------------------------------
// lkvc_cell
// One recency position of the cache row. Position 0 is most recent. On a set
// the cell loads its upstream neighbor's entry when it lies in the shifted span.
// ----------------------------------------------------------------------------
module lkvc_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkvc_pkg::t_cell_cmd         i_cmd,
    input  logic [lkvc_pkg::KEY_W-1:0]  i_key,        // key under lookup
    input  logic [lkvc_pkg::KEY_W-1:0]  i_prev_key,   // entry of the younger neighbor
    input  logic [lkvc_pkg::DATA_W-1:0] i_prev_data,
    input  logic                        i_prev_valid,
    input  logic                        i_sfx_hit,    // hit at some older position
    input  logic [lkvc_pkg::DATA_W-1:0] i_rdata,      // read data chain in
    output logic [lkvc_pkg::KEY_W-1:0]  o_key,
    output logic [lkvc_pkg::DATA_W-1:0] o_data,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic                        o_sfx_hit,    // hit here or older
    output logic [lkvc_pkg::DATA_W-1:0] o_rdata       // read data chain out
);

    logic [lkvc_pkg::KEY_W-1:0]  r_key;
    logic [lkvc_pkg::DATA_W-1:0] r_data;
    logic                        r_valid;
    logic                        w_hit;
    logic                        w_shift;

    // tag compare
    assign w_hit     = r_valid && (r_key == i_key);
    assign o_hit     = w_hit;
    assign o_sfx_hit = w_hit || i_sfx_hit;
    assign o_rdata   = i_rdata | (w_hit ? r_data : '0);

    // hit: shift positions up to the hit; miss: shift the filled span, plus
    // the first empty cell unless the oldest entry is being dropped
    always_comb begin
        if (i_cmd.hit_any) begin
            w_shift = i_cmd.update && o_sfx_hit;
        end else begin
            w_shift = i_cmd.update && (r_valid || (i_prev_valid && !i_cmd.evict));
        end
    end

    // entry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev_valid;
        end
    end

    // key and data, no reset
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key  <= i_prev_key;
            r_data <= i_prev_data;
        end
    end

    assign o_key   = r_key;
    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with LRU replacement, built as a row of
// cells ordered by recency.
// ----------------------------------------------------------------------------
// A get result is captured in the result register when the get executes.
// Each beat is accepted, then executed: every cell compares its key and the row
//   shifts in the same cycle. No new beat is accepted until execute is done.
// A get waits in execute while an earlier result is not yet taken.
// Reset clears all valid bits and the entry count, capacity returns to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic [0:0]                     s_tuser,   // [0] action (0 get, 1 set)
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [31:0] read_value
    output logic [0:0]                     m_tuser    // [0] found
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                          r_state;
    logic                          n_state;
    logic                          r_action;
    logic [lkvc_pkg::KEY_W-1:0]    r_key;
    logic [lkvc_pkg::DATA_W-1:0]   r_value;
    logic [lkvc_pkg::CAP_W-1:0]    r_capacity;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic                          r_out_valid;
    logic                          r_out_found;
    logic [lkvc_pkg::DATA_W-1:0]   r_out_data;

    logic                          w_go;
    logic [CMP_W-1:0]              w_cap;
    logic                          w_evict;
    lkvc_pkg::t_cell_cmd           w_cmd;

    logic [lkvc_pkg::KEY_W-1:0]    w_ckey   [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0]   w_cdata  [ENTRIES];
    logic [ENTRIES-1:0]            w_cvalid;
    logic [ENTRIES-1:0]            w_chit;
    logic [ENTRIES:0]              w_sfx;
    logic [lkvc_pkg::DATA_W-1:0]   w_rd     [ENTRIES+1];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // effective capacity: zero acts as one, clamp to the row length
    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(ENTRIES)) begin
            w_cap = CMP_W'(ENTRIES);
        end else begin
            w_cap = CMP_W'(r_capacity);
        end
    end
    assign w_evict = CMP_W'(r_count) >= w_cap;

    // sequencer
    assign s_tready = (r_state == ST_IDLE);
    assign w_go     = (r_state == ST_EXEC) && (r_action || !r_out_valid || m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_action <= s_tuser[0];
            r_key    <= s_tdata[31:0];
            r_value  <= s_tdata[63:32];
        end
    end

    // command to the cell row
    assign w_cmd.update  = w_go && r_action;
    assign w_cmd.hit_any = w_sfx[0];
    assign w_cmd.evict   = w_evict;

    // entry count grows only on a miss that keeps the oldest entry
    always_comb begin
        n_count = r_count;
        if (w_cmd.update && !w_sfx[0] && !w_evict) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // cell row: hit flags ripple toward the head, read data toward the tail
    assign w_sfx[ENTRIES] = 1'b0;
    assign w_rd[0]        = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [lkvc_pkg::KEY_W-1:0]  w_pkey;
        logic [lkvc_pkg::DATA_W-1:0] w_pdata;
        logic                        w_pvalid;

        if (g == 0) begin : g_head
            assign w_pkey   = r_key;
            assign w_pdata  = r_value;
            assign w_pvalid = 1'b1;
        end else begin : g_body
            assign w_pkey   = w_ckey[g-1];
            assign w_pdata  = w_cdata[g-1];
            assign w_pvalid = w_cvalid[g-1];
        end

        lkvc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_key        (r_key),
            .i_prev_key   (w_pkey),
            .i_prev_data  (w_pdata),
            .i_prev_valid (w_pvalid),
            .i_sfx_hit    (w_sfx[g+1]),
            .i_rdata      (w_rd[g]),
            .o_key        (w_ckey[g]),
            .o_data       (w_cdata[g]),
            .o_valid      (w_cvalid[g]),
            .o_hit        (w_chit[g]),
            .o_sfx_hit    (w_sfx[g]),
            .o_rdata      (w_rd[g+1])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && !r_action) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && !r_action) begin
            r_out_found <= w_sfx[0];
            r_out_data  <= w_sfx[0] ? w_rd[ENTRIES] : lkvc_pkg::MISS_VALUE;
        end
    end

    assign m_tvalid   = r_out_valid;
    assign m_tdata    = r_out_data;
    assign m_tuser[0] = r_out_found;

    // checks
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_cvalid) == int'(r_count))
        else $error("entry count differs from number of valid cells");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= ENTRIES)
        else $error("entry count beyond row length");

    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_chit))
        else $error("key present in more than one cell");

    a_miss_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.update && !w_sfx[0] && !w_evict) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("set miss without eviction did not add an entry");

endmodule

// ===== tb/tb_lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Self-checking bench for the LRU key-value cache. A recency-ordered queue
// tracks what the cache must hold. Every get result is compared with the
// value that queue predicts, or with a value typed into the directed table.
// A directed table runs first. Random phases follow, each with its own
// capacity and key pool. Both stream sides stall at random, except in one
// burst phase.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;

    localparam int ENTRIES        = 16;
    localparam int DRAIN_CYCLES   = 4;      // idle margin after the last reply; sets give nothing
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASES         = 8;
    localparam int BEATS_PER_PHASE = 80;
    localparam int POOL_MAX       = 24;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    typedef enum logic [1:0] {ROW_GET, ROW_SET, ROW_CFG} t_row_kind;

    // one directed step; value carries the capacity on a config row
    typedef struct packed {
        t_row_kind                   kind;
        logic [lkvc_pkg::KEY_W-1:0]  key;
        logic [lkvc_pkg::DATA_W-1:0] value;
        logic                        pinned;      // expectation typed in below
        logic                        found_exp;
        logic [lkvc_pkg::DATA_W-1:0] value_exp;
    } t_row;

    typedef struct packed {
        logic [lkvc_pkg::KEY_W-1:0]  key;
        logic [lkvc_pkg::DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic                        found;
        logic [lkvc_pkg::DATA_W-1:0] value;
    } t_reply;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0] i_cfg_wdata = '0;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [63:0]                s_tdata     = '0;    // [31:0] lookup_key, [63:32] write_value
    logic [0:0]                 s_tuser     = '0;    // [0] action (0 get, 1 set)
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [31:0]                m_tdata;             // [31:0] read_value
    logic [0:0]                 m_tuser;             // [0] found

    // model of the store: index 0 is the most recent entry
    t_entry                      recency_q[$];
    logic [lkvc_pkg::CAP_W-1:0]  cap_reg = lkvc_pkg::CAP_RESET;
    t_reply                      reply_q[$];

    // typed-in expectation that travels with the beat being offered
    logic                        pin_valid = 1'b0;
    logic                        pin_found = 1'b0;
    logic [lkvc_pkg::DATA_W-1:0] pin_value = '0;

    logic              burst = 1'b0;        // no idling on either side
    int                fail_count = 0;
    int                cycle_count = 0;

    t_row directed_rows [23] = '{
        '{ROW_GET, 32'd5,         32'h1234_5678, 1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
        '{ROW_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'h7FFF_FFFF, 32'h0,         1'b1, 1'b1, 32'h8000_0000},
        '{ROW_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{ROW_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'hFFFF_FFFF, 32'h0,         1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_SET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'h0,         32'hA5A5_A5A5, 1'b1, 1'b1, 32'h0},
        '{ROW_GET, 32'h7FFF_FFFE, 32'h0,         1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
        // set that hits: new value, entry becomes most recent
        '{ROW_SET, 32'h7FFF_FFFF, 32'h1,         1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'h7FFF_FFFF, 32'h0,         1'b1, 1'b1, 32'h1},
        // capacity dropped below the count: one out, one in per missing set
        '{ROW_CFG, 32'h0,         32'd2,         1'b0, 1'b0, 32'h0},
        '{ROW_SET, 32'h1,         32'd11,        1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'h8000_0000, 32'h0,         1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
        '{ROW_GET, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 32'h0},
        // zero capacity acts as one
        '{ROW_CFG, 32'h0,         32'd0,         1'b0, 1'b0, 32'h0},
        '{ROW_SET, 32'h2,         32'd22,        1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'h2,         32'h0,         1'b0, 1'b0, 32'h0},
        // capacity above the cell count saturates
        '{ROW_CFG, 32'h0,         32'd31,        1'b0, 1'b0, 32'h0},
        '{ROW_SET, 32'h3,         32'd33,        1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
        '{ROW_GET, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 32'h0}
    };

    logic [lkvc_pkg::CAP_W-1:0] phase_caps [PHASES] = '{
        5'd16, 5'd1, 5'd3, 5'd8, 5'd16, 5'd17, 5'd2, 5'd12
    };

    lru_key_value_cache_top #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side backpressure
    always @(negedge i_clk) begin
        m_tready = burst || ($urandom_range(0, 99) >= 30);
    end

    // Check results first, then fold in this edge's config write and input
    // beat, so a push and a pop on the same edge never race.
    always @(posedge i_clk) begin : cache_monitor
        t_reply want;
        t_entry ent;
        int     hit_at;
        int     keep;
        if (!i_rst_n) begin
            recency_q.delete();
            reply_q.delete();
            cap_reg = lkvc_pkg::CAP_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result beat, found %0b value %h",
                             $time, m_tuser[0], m_tdata);
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_tuser[0] !== want.found || m_tdata !== want.value) begin
                        $display({"%0t: get mismatch, expected found %0b value %h,",
                                  " got found %0b value %h"},
                                 $time, want.found, want.value, m_tuser[0], m_tdata);
                        fail_count++;
                    end
                end
            end

            if (i_cfg_we)
                cap_reg = i_cfg_wdata;

            if (s_tvalid && s_tready) begin
                hit_at = -1;
                foreach (recency_q[i])
                    if (recency_q[i].key == s_tdata[31:0])
                        hit_at = i;
                if (s_tuser[0] == ACT_GET) begin
                    if (pin_valid)
                        want = '{pin_found, pin_value};
                    else if (hit_at >= 0)
                        want = '{1'b1, recency_q[hit_at].data};
                    else
                        want = '{1'b0, lkvc_pkg::MISS_VALUE};
                    reply_q.push_back(want);
                end else if (hit_at >= 0) begin
                    // overwrite and move to the front
                    ent      = recency_q[hit_at];
                    ent.data = s_tdata[63:32];
                    recency_q.delete(hit_at);
                    recency_q.push_front(ent);
                end else begin
                    // insert, dropping the oldest when at capacity
                    keep = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
                    if (recency_q.size() >= keep)
                        void'(recency_q.pop_back());
                    ent.key  = s_tdata[31:0];
                    ent.data = s_tdata[63:32];
                    recency_q.push_front(ent);
                end
            end
        end
    end

    // offer one access beat, with random idle cycles ahead of it
    task automatic send_access(input logic act, input logic [lkvc_pkg::KEY_W-1:0] key,
                               input logic [lkvc_pkg::DATA_W-1:0] value,
                               input logic pinned, input logic found_exp,
                               input logic [lkvc_pkg::DATA_W-1:0] value_exp);
        while (!burst && $urandom_range(0, 99) < 30) begin
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom};
            @(negedge i_clk);
        end
        s_tvalid  = 1'b1;
        s_tuser   = act;
        s_tdata   = {value, key};
        pin_valid = pinned;
        pin_found = found_exp;
        pin_value = value_exp;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every get has been answered
    task automatic drain;
        s_tvalid = 1'b0;
        while (reply_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        t_row                       row;
        logic                       act;
        logic [lkvc_pkg::KEY_W-1:0] key;
        logic [lkvc_pkg::KEY_W-1:0] key_pool [POOL_MAX];
        int                         npool;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            case (row.kind)
                ROW_CFG: begin
                    write_capacity(row.value[lkvc_pkg::CAP_W-1:0]);
                end
                ROW_GET: begin
                    send_access(ACT_GET, row.key, row.value, row.pinned,
                                row.found_exp, row.value_exp);
                end
                default: begin
                    send_access(ACT_SET, row.key, row.value, 1'b0, 1'b0, '0);
                end
            endcase
        end

        // random phases: mostly keys from a small pool so gets hit and sets
        // both overwrite and evict, with some keys from the full range
        for (int ph = 0; ph < PHASES; ph++) begin
            write_capacity(phase_caps[ph]);
            burst = (ph == 4);
            npool = $urandom_range(2, POOL_MAX);
            for (int k = 0; k < npool; k++)
                key_pool[k] = $urandom;
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                act = ($urandom_range(0, 99) < 50) ? ACT_SET : ACT_GET;
                key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, npool - 1)]
                                                   : $urandom;
                send_access(act, key, $urandom, 1'b0, 1'b0, '0);
            end
            burst = 1'b0;
        end

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_cell.sv
hw/rtl/lru_key_value_cache_top.sv
tb/tb_lru_key_value_cache_top.sv
